// ----- src/pmmu_pkg.sv -----
// Shared types and constants of the paging MMU.
// Used by pmmu_ctrl, pmmu_dp, paged_memory_lru_mmu and the testbench; depends on nothing.
package pmmu_pkg;

  localparam int DEF_NUM_PROCESSES = 4;
  localparam int DEF_NUM_FRAMES    = 8;
  localparam int DEF_DATA_WIDTH    = 16;

  localparam int PAGE_BITS  = 4;
  localparam int PAGES      = 16;
  localparam int OFFS_BITS  = 6;
  localparam int PAGE_WORDS = 64;
  localparam int AGE_W      = 5;
  localparam int PROC_W     = 2;
  localparam int ADDR_W     = 10;
  localparam int IO_DATA_W  = 16;
  localparam int OP_W       = 2;
  localparam int FRAME_POS  = 12;

  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic tbl_vic;
    logic scan;
    logic pick;
    logic vframe;
    logic wback;
    logic load;
    logic install;
    logic access;
    logic clear;
    logic respond;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_nop;
    logic hit;
    logic free_found;
    logic vic_found;
    logic out_free;
  } sts_t;

endpackage

// ----- src/paged_memory_lru_mmu.sv -----
// Top level of the demand-paging MMU with least-recently-stamped replacement.
// Instantiates pmmu_ctrl and pmmu_dp; depends on pmmu_pkg.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o  | operation, process_id, logical_address,
//           |           |                          | write_data, age_stamp
//   out     | output    | out_valid_o / out_stall_i| read_data, physical_address, page_fault,
//           |           |                          | evicted, evicted_process, evicted_page
//
// A hit looks up the page table, accesses the frame and registers its result; a miss into a
// free frame also loads the page from backing memory first. A miss with eviction also scans
// the age table one entry a cycle, frees the victim and writes its page back before the load.
// An age clear zeroes every age entry before its result is registered.
// No clearing pass after reset; the next item is taken while a result waits.
module paged_memory_lru_mmu #(
  parameter int NUM_PROCESSES = pmmu_pkg::DEF_NUM_PROCESSES,
  parameter int NUM_FRAMES    = pmmu_pkg::DEF_NUM_FRAMES,
  parameter int DATA_WIDTH    = pmmu_pkg::DEF_DATA_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [pmmu_pkg::OP_W-1:0]      operation_i,
  input  logic [pmmu_pkg::PROC_W-1:0]    process_id_i,
  input  logic [pmmu_pkg::ADDR_W-1:0]    logical_address_i,
  input  logic [pmmu_pkg::IO_DATA_W-1:0] write_data_i,
  input  logic [pmmu_pkg::AGE_W-1:0]     age_stamp_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [pmmu_pkg::IO_DATA_W-1:0] read_data_o,
  output logic [pmmu_pkg::IO_DATA_W-1:0] physical_address_o,
  output logic                           page_fault_o,
  output logic                           evicted_o,
  output logic [pmmu_pkg::PROC_W-1:0]    evicted_process_o,
  output logic [pmmu_pkg::PAGE_BITS-1:0] evicted_page_o
);
  import pmmu_pkg::*;

  localparam int ENT   = NUM_PROCESSES * PAGES;
  localparam int CMAX  = (ENT > PAGE_WORDS) ? ENT : PAGE_WORDS;
  localparam int CNT_W = $clog2(CMAX + 1);

  cmd_t             cmd;
  sts_t             sts;
  logic [CNT_W-1:0] cnt;

  pmmu_ctrl #(
    .NUM_PROCESSES(NUM_PROCESSES),
    .CNT_W        (CNT_W)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .cnt_o     (cnt)
  );

  pmmu_dp #(
    .NUM_PROCESSES(NUM_PROCESSES),
    .NUM_FRAMES   (NUM_FRAMES),
    .DATA_WIDTH   (DATA_WIDTH),
    .CNT_W        (CNT_W)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cnt_i             (cnt),
    .sts_o             (sts),
    .operation_i       (operation_i),
    .process_id_i      (process_id_i),
    .logical_address_i (logical_address_i),
    .write_data_i      (write_data_i),
    .age_stamp_i       (age_stamp_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .read_data_o       (read_data_o),
    .physical_address_o(physical_address_o),
    .page_fault_o      (page_fault_o),
    .evicted_o         (evicted_o),
    .evicted_process_o (evicted_process_o),
    .evicted_page_o    (evicted_page_o)
  );

endmodule

// ----- src/pmmu_dp.sv -----
// Datapath of the paging MMU: item registers, page tables, frame and backing
// memories, victim search and result register. Depends on pmmu_pkg.
module pmmu_dp #(
  parameter int NUM_PROCESSES = pmmu_pkg::DEF_NUM_PROCESSES,
  parameter int NUM_FRAMES    = pmmu_pkg::DEF_NUM_FRAMES,
  parameter int DATA_WIDTH    = pmmu_pkg::DEF_DATA_WIDTH,
  parameter int CNT_W         = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pmmu_pkg::cmd_t                      cmd_i,
  input  logic [CNT_W-1:0]                    cnt_i,
  output pmmu_pkg::sts_t                      sts_o,
  input  logic [pmmu_pkg::OP_W-1:0]           operation_i,
  input  logic [pmmu_pkg::PROC_W-1:0]         process_id_i,
  input  logic [pmmu_pkg::ADDR_W-1:0]         logical_address_i,
  input  logic [pmmu_pkg::IO_DATA_W-1:0]      write_data_i,
  input  logic [pmmu_pkg::AGE_W-1:0]          age_stamp_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [pmmu_pkg::IO_DATA_W-1:0]      read_data_o,
  output logic [pmmu_pkg::IO_DATA_W-1:0]      physical_address_o,
  output logic                                page_fault_o,
  output logic                                evicted_o,
  output logic [pmmu_pkg::PROC_W-1:0]         evicted_process_o,
  output logic [pmmu_pkg::PAGE_BITS-1:0]      evicted_page_o
);
  import pmmu_pkg::*;

  localparam int ENT = NUM_PROCESSES * PAGES;
  localparam int IW  = $clog2(ENT);
  localparam int FW  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int MW  = FW + OFFS_BITS;
  localparam int BW  = IW + OFFS_BITS;

  logic [OP_W-1:0]       op_q;
  logic [PROC_W-1:0]     proc_q;
  logic [PAGE_BITS-1:0]  page_q;
  logic [OFFS_BITS-1:0]  offs_q;
  logic [DATA_WIDTH-1:0] wdata_q;
  logic [AGE_W-1:0]      stamp_q;
  logic [FW-1:0]         cur_q;
  logic                  fault_q;
  logic                  ev_q;
  logic                  found_q;
  logic [AGE_W-1:0]      best_q;
  logic [IW-1:0]         vic_q;

  logic [ENT-1:0]        valid_q;
  logic [ENT-1:0]        wb_q;
  logic [NUM_FRAMES-1:0] busy_q;
  logic                  out_valid_q;

  logic [FW-1:0]         tbl_mem [ENT];
  logic [AGE_W-1:0]      age_mem [ENT];
  logic [DATA_WIDTH-1:0] frame_mem [NUM_FRAMES*PAGE_WORDS];
  logic [DATA_WIDTH-1:0] back_mem [ENT*PAGE_WORDS];
  logic [FW-1:0]         tbl_rd_q;
  logic [AGE_W-1:0]      age_rd_q;
  logic [DATA_WIDTH-1:0] fm_rd_q;
  logic [DATA_WIDTH-1:0] bk_rd_q;

  logic [IW-1:0]         idx;
  logic [IW-1:0]         tbl_addr;
  logic [IW-1:0]         cnt_idx;
  logic [IW-1:0]         prev_idx;
  logic [CNT_W-1:0]      cnt_m1;
  logic [FW-1:0]         free_idx;
  logic                  free_found;
  logic                  zero_res;
  logic                  age_we;
  logic [IW-1:0]         age_wa;
  logic [AGE_W-1:0]      age_wd;
  logic                  fm_re;
  logic [MW-1:0]         fm_ra;
  logic                  fm_we;
  logic [MW-1:0]         fm_wa;
  logic [DATA_WIDTH-1:0] fm_wd;
  logic                  bk_we;
  logic [BW-1:0]         bk_wa;
  logic [BW-1:0]         bk_ra;

  assign idx      = IW'({proc_q, page_q});
  assign tbl_addr = cmd_i.tbl_vic ? vic_q : idx;
  assign cnt_idx  = cnt_i[IW-1:0];
  assign cnt_m1   = cnt_i - 1'b1;
  assign prev_idx = cnt_m1[IW-1:0];
  assign zero_res = (op_q == OP_CLEAR) || (op_q == OP_NONE) ||
                    (int'(proc_q) >= NUM_PROCESSES);

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int f = NUM_FRAMES - 1; f >= 0; f--) begin
      if (!busy_q[f]) begin
        free_idx   = FW'(f);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    age_we = cmd_i.access || cmd_i.clear;
    age_wa = cmd_i.clear ? cnt_idx : idx;
    age_wd = cmd_i.clear ? '0 : stamp_q;
    fm_re  = cmd_i.wback || (cmd_i.access && (op_q == OP_READ));
    fm_ra  = cmd_i.wback ? {cur_q, cnt_i[OFFS_BITS-1:0]} : {cur_q, offs_q};
    fm_we  = (cmd_i.load && (cnt_i != '0)) || (cmd_i.access && (op_q == OP_WRITE));
    fm_wa  = cmd_i.load ? {cur_q, cnt_m1[OFFS_BITS-1:0]} : {cur_q, offs_q};
    fm_wd  = cmd_i.load ? (wb_q[idx] ? bk_rd_q : '0) : wdata_q;
    bk_we  = cmd_i.wback && (cnt_i != '0);
    bk_wa  = {vic_q, cnt_m1[OFFS_BITS-1:0]};
    bk_ra  = {idx, cnt_i[OFFS_BITS-1:0]};
  end

  always_ff @(posedge clk_i) begin
    tbl_rd_q <= tbl_mem[tbl_addr];
    if (cmd_i.install) begin
      tbl_mem[idx] <= cur_q;
    end
  end

  always_ff @(posedge clk_i) begin
    age_rd_q <= age_mem[cnt_idx];
    if (age_we) begin
      age_mem[age_wa] <= age_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fm_re) begin
      fm_rd_q <= frame_mem[fm_ra];
    end
    if (fm_we) begin
      frame_mem[fm_wa] <= fm_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bk_rd_q <= back_mem[bk_ra];
    end
    if (bk_we) begin
      back_mem[bk_wa] <= fm_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= operation_i;
      proc_q  <= process_id_i;
      page_q  <= logical_address_i[ADDR_W-1:OFFS_BITS];
      offs_q  <= logical_address_i[OFFS_BITS-1:0];
      wdata_q <= DATA_WIDTH'(write_data_i);
      stamp_q <= age_stamp_i;
      fault_q <= 1'b0;
      ev_q    <= 1'b0;
      found_q <= 1'b0;
    end
    if (cmd_i.lookup) begin
      if (valid_q[idx]) begin
        cur_q <= tbl_rd_q;
      end else begin
        fault_q <= 1'b1;
        if (free_found) begin
          cur_q <= free_idx;
        end
      end
    end
    if (cmd_i.scan && (cnt_i != '0)) begin
      if (valid_q[prev_idx] && (!found_q || (age_rd_q < best_q))) begin
        found_q <= 1'b1;
        best_q  <= age_rd_q;
        vic_q   <= prev_idx;
      end
    end
    if (cmd_i.pick && !found_q) begin
      cur_q <= '0;
    end
    if (cmd_i.vframe) begin
      cur_q <= tbl_rd_q;
      ev_q  <= 1'b1;
    end
    if (cmd_i.respond) begin
      read_data_o        <= (!zero_res && (op_q == OP_READ)) ? IO_DATA_W'(fm_rd_q) : '0;
      physical_address_o <= zero_res ? '0 :
                            ((IO_DATA_W'(cur_q) << FRAME_POS) | IO_DATA_W'(offs_q));
      page_fault_o       <= !zero_res && fault_q;
      evicted_o          <= !zero_res && ev_q;
      evicted_process_o  <= (!zero_res && ev_q) ? PROC_W'(vic_q >> PAGE_BITS) : '0;
      evicted_page_o     <= (!zero_res && ev_q) ? vic_q[PAGE_BITS-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      wb_q        <= '0;
      busy_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.vframe) begin
        valid_q[vic_q]   <= 1'b0;
        wb_q[vic_q]      <= 1'b1;
        busy_q[tbl_rd_q] <= 1'b0;
      end
      if (cmd_i.install) begin
        valid_q[idx]  <= 1'b1;
        busy_q[cur_q] <= 1'b1;
      end
      if (cmd_i.respond) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o.is_clear   = (op_q == OP_CLEAR);
    sts_o.is_nop     = zero_res && (op_q != OP_CLEAR);
    sts_o.hit        = valid_q[idx];
    sts_o.free_found = free_found;
    sts_o.vic_found  = found_q;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

endmodule

// ----- src/pmmu_ctrl.sv -----
// Controller of the paging MMU: one-hot state machine and step counter.
// Drives pmmu_dp through pmmu_pkg::cmd_t; depends on pmmu_pkg.
module pmmu_ctrl #(
  parameter int NUM_PROCESSES = pmmu_pkg::DEF_NUM_PROCESSES,
  parameter int CNT_W         = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pmmu_pkg::sts_t   sts_i,
  output pmmu_pkg::cmd_t   cmd_o,
  output logic [CNT_W-1:0] cnt_o
);
  import pmmu_pkg::*;

  localparam int ENT = NUM_PROCESSES * PAGES;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_DECODE  = 12'b000000000010,
    S_LOOKUP  = 12'b000000000100,
    S_CLEAR   = 12'b000000001000,
    S_SCAN    = 12'b000000010000,
    S_PICK    = 12'b000000100000,
    S_VFRAME  = 12'b000001000000,
    S_WBACK   = 12'b000010000000,
    S_LOAD    = 12'b000100000000,
    S_INSTALL = 12'b001000000000,
    S_ACCESS  = 12'b010000000000,
    S_RESP    = 12'b100000000000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + 1'b1;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        cnt_d = '0;
        if (sts_i.is_clear) begin
          state_d = S_CLEAR;
        end else if (sts_i.is_nop) begin
          state_d = S_RESP;
        end else begin
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        cnt_d        = '0;
        if (sts_i.hit) begin
          state_d = S_ACCESS;
        end else if (sts_i.free_found) begin
          state_d = S_LOAD;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (cnt_q == CNT_W'(ENT - 1)) begin
          state_d = S_RESP;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (cnt_q == CNT_W'(ENT)) begin
          state_d = S_PICK;
        end
      end
      S_PICK: begin
        cmd_o.pick    = 1'b1;
        cmd_o.tbl_vic = 1'b1;
        cnt_d         = '0;
        state_d       = sts_i.vic_found ? S_VFRAME : S_LOAD;
      end
      S_VFRAME: begin
        cmd_o.vframe = 1'b1;
        cnt_d        = '0;
        state_d      = S_WBACK;
      end
      S_WBACK: begin
        cmd_o.wback = 1'b1;
        if (cnt_q == CNT_W'(PAGE_WORDS)) begin
          cnt_d   = '0;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        if (cnt_q == CNT_W'(PAGE_WORDS)) begin
          state_d = S_INSTALL;
        end
      end
      S_INSTALL: begin
        cmd_o.install = 1'b1;
        state_d       = S_ACCESS;
      end
      S_ACCESS: begin
        cmd_o.access = 1'b1;
        state_d      = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.respond = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign cnt_o      = cnt_q;

endmodule

// ----- dv/tb_paged_memory_lru_mmu.sv -----
// Testbench for paged_memory_lru_mmu: random reads, writes, age clears and no-ops with stalls.
// A scoreboard class predicts translation, faults, LRU eviction and page data.
// Depends on pmmu_pkg and the paged_memory_lru_mmu RTL.
module tb_paged_memory_lru_mmu;
  timeunit 1ns;
  timeprecision 1ps;
  import pmmu_pkg::*;

  localparam int NPROC = 4;
  localparam int NFRM  = 8;

  typedef struct packed {
    logic [15:0] rdata;
    logic [15:0] paddr;
    logic        fault;
    logic        ev;
    logic [1:0]  ev_proc;
    logic [3:0]  ev_page;
  } mmu_result_t;

  class mmu_scoreboard;
    bit          pt_valid [NPROC][PAGES];
    logic [2:0]  pt_frame [NPROC][PAGES];
    logic [4:0]  pt_age [NPROC][PAGES];
    logic [15:0] frame_mem [NFRM][PAGE_WORDS];
    logic [15:0] backing_mem [NPROC][PAGES][PAGE_WORDS];
    bit          frame_busy [NFRM];
    mmu_result_t pending_results[$];
    int          errors;

    function new();
      errors = 0;
      foreach (pt_valid[p, g]) begin
        pt_valid[p][g] = 0;
        pt_frame[p][g] = '0;
        pt_age[p][g] = '0;
      end
      foreach (frame_mem[f, w]) frame_mem[f][w] = '0;
      foreach (backing_mem[p, g, w]) backing_mem[p][g][w] = '0;
      foreach (frame_busy[f]) frame_busy[f] = 0;
    endfunction

    function void note_transfer(logic [1:0] op, logic [1:0] pid, logic [9:0] la,
                                logic [15:0] wd, logic [4:0] stamp);
      mmu_result_t r;
      int pg, offs, fr, bp, bg;
      bit found;
      logic [4:0] best;
      r = '0;
      pg = la[9:6];
      offs = la[5:0];
      if (op == OP_CLEAR) begin
        foreach (pt_age[p, g]) pt_age[p][g] = '0;
      end else if (op != OP_NONE) begin
        if (pt_valid[pid][pg]) begin
          fr = pt_frame[pid][pg];
        end else begin
          r.fault = 1;
          fr = -1;
          for (int f = 0; f < NFRM; f++)
            if (fr < 0 && !frame_busy[f]) fr = f;
          if (fr < 0) begin
            found = 0;
            best = '0;
            bp = 0;
            bg = 0;
            for (int p = 0; p < NPROC; p++)
              for (int g = 0; g < PAGES; g++)
                if (pt_valid[p][g] && (!found || pt_age[p][g] < best)) begin
                  found = 1;
                  best = pt_age[p][g];
                  bp = p;
                  bg = g;
                end
            fr = pt_frame[bp][bg];
            for (int w = 0; w < PAGE_WORDS; w++) backing_mem[bp][bg][w] = frame_mem[fr][w];
            pt_valid[bp][bg] = 0;
            pt_frame[bp][bg] = '0;
            pt_age[bp][bg] = '0;
            r.ev = 1;
            r.ev_proc = 2'(bp);
            r.ev_page = 4'(bg);
          end
          for (int w = 0; w < PAGE_WORDS; w++) frame_mem[fr][w] = backing_mem[pid][pg][w];
          frame_busy[fr] = 1;
          pt_valid[pid][pg] = 1;
          pt_frame[pid][pg] = 3'(fr);
        end
        pt_age[pid][pg] = stamp;
        if (op == OP_WRITE) frame_mem[fr][offs] = wd;
        else r.rdata = frame_mem[fr][offs];
        r.paddr = 16'((fr << FRAME_POS) | offs);
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(mmu_result_t act);
      mmu_result_t exp;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, act);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (act.rdata !== exp.rdata)
        $display("%0t: read_data exp %h act %h", $time, exp.rdata, act.rdata);
      if (act.paddr !== exp.paddr)
        $display("%0t: physical_address exp %h act %h", $time, exp.paddr, act.paddr);
      if (act.fault !== exp.fault)
        $display("%0t: page_fault exp %b act %b", $time, exp.fault, act.fault);
      if (act.ev !== exp.ev)
        $display("%0t: evicted exp %b act %b", $time, exp.ev, act.ev);
      if (act.ev_proc !== exp.ev_proc)
        $display("%0t: evicted_process exp %h act %h", $time, exp.ev_proc, act.ev_proc);
      if (act.ev_page !== exp.ev_page)
        $display("%0t: evicted_page exp %h act %h", $time, exp.ev_page, act.ev_page);
      if (act !== exp) errors++;
    endfunction
  endclass

  logic        clk_i = 0, rst_ni = 0;
  logic        in_valid_i = 0, in_stall_o, out_valid_o, out_stall_i = 0;
  logic [1:0]  operation_i = '0, process_id_i = '0;
  logic [9:0]  logical_address_i = '0;
  logic [15:0] write_data_i = '0;
  logic [4:0]  age_stamp_i = '0;
  logic [15:0] read_data_o, physical_address_o;
  logic        page_fault_o, evicted_o;
  logic [1:0]  evicted_process_o;
  logic [3:0]  evicted_page_o;
  bit          sending_done = 0;
  bit          hold_off = 0;
  int          out_wait = 0;

  mmu_scoreboard sb = new();

  paged_memory_lru_mmu uut (.*);

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  task automatic send_access(logic [1:0] op, logic [1:0] pid, logic [9:0] la,
                             logic [15:0] wd, logic [4:0] stamp);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1;
    operation_i <= op;
    process_id_i <= pid;
    logical_address_i <= la;
    write_data_i <= wd;
    age_stamp_i <= stamp;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_transfer(op, pid, la, wd, stamp);
    @(negedge clk_i);
  endtask

  function automatic logic [1:0] pick_op();
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) return OP_READ;
    if (k < 90) return OP_WRITE;
    if (k < 96) return OP_CLEAR;
    return OP_NONE;
  endfunction

  initial begin
    logic [9:0] la;
    repeat (3) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    send_access(OP_READ, 2'd0, 10'd0, 16'h0000, 5'd0);
    send_access(OP_WRITE, 2'd0, 10'd1023, 16'hFFFF, 5'd31);
    send_access(OP_READ, 2'd0, 10'd1023, 16'h0000, 5'd31);
    send_access(OP_WRITE, 2'd3, 10'd0, 16'hA5A5, 5'd1);
    for (int i = 0; i < 8; i++)
      send_access(OP_WRITE, i[1:0], {i[3:0] + 4'd4, 6'd5}, 16'(16'h1000 + i), 5'(i + 2));
    send_access(OP_WRITE, 2'd2, 10'd63, 16'h5A5A, 5'd20);
    send_access(OP_READ, 2'd0, 10'd1023, 16'h0000, 5'd3);
    send_access(OP_CLEAR, 2'd1, 10'd0, 16'h0000, 5'd0);
    send_access(OP_NONE, 2'd1, 10'd512, 16'h1234, 5'd9);
    send_access(OP_READ, 2'd3, 10'd0, 16'h0000, 5'd7);
    send_access(OP_READ, 2'd1, 10'd325, 16'h0000, 5'd7);
    for (int n = 0; n < 1600; n++) begin
      la = 10'($urandom_range(0, 1023));
      if ($urandom_range(0, 2) != 0) la[9:6] = 4'($urandom_range(0, 3));
      send_access(pick_op(), 2'($urandom_range(0, 3)), la, 16'($urandom_range(0, 65535)),
                  5'($urandom_range(0, 31)));
    end
    in_valid_i <= 0;
    sending_done = 1;
  end

  initial begin
    @(posedge rst_ni);
    repeat (200) @(posedge clk_i);
    hold_off = 1;
    repeat (3000) @(posedge clk_i);
    hold_off = 0;
  end

  always @(negedge clk_i) begin
    if (hold_off) begin
      out_stall_i <= 1;
    end else if (out_wait > 0) begin
      out_stall_i <= 1;
      out_wait = out_wait - 1;
    end else begin
      out_stall_i <= 0;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result({read_data_o, physical_address_o, page_fault_o, evicted_o,
                       evicted_process_o, evicted_page_o});
      out_wait = $urandom_range(0, 8);
    end

  initial begin
    wait (sending_done);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_results.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end
endmodule
